/* design/ordered_key_set_engine_assert.svh */
// Assertion macros used by the set engine datapath
`ifndef ORDERED_KEY_SET_ENGINE_ASSERT_SVH
`define ORDERED_KEY_SET_ENGINE_ASSERT_SVH

// Check that a condition holds on every rising clock edge outside reset
`define OKS_ASSERT(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent on the next edge
`define OKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/okse_pkg.sv */
`default_nettype none
package okse_pkg;

  localparam int Capacity = 256;
  localparam int AddrW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_EXISTS = 3'd2,
    OP_PRED   = 3'd3,
    OP_SUCC   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FOUND = 2'd1,
    ST_NONE  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_FETCH,
    S_WAIT,
    S_SHIFT,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic fetch;
    logic decide;
    logic shift_step;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic shift_done;
  } sts_t;

  typedef struct packed {
    logic [2:0] operation;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic signed [31:0] value;
    logic [8:0] stored_count;
  } rsp_t;

endpackage
`default_nettype wire

/* design/okse_channel_if.sv */
`default_nettype none
interface okse_req_if;
  logic valid;
  logic ready;
  okse_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface okse_rsp_if;
  logic valid;
  logic ready;
  okse_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* design/okse_ctrl.sv */
`default_nettype none
module okse_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic out_fire,
  input  wire logic need_shift,
  input  wire okse_pkg::sts_t sts,
  output okse_pkg::cmd_t cmd,
  output logic busy,
  output logic out_valid
);

  okse_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= okse_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      okse_pkg::S_IDLE: if (in_fire) state_next = okse_pkg::S_SEARCH;
      okse_pkg::S_SEARCH: if (sts.search_done) state_next = okse_pkg::S_FETCH;
      okse_pkg::S_FETCH: state_next = okse_pkg::S_WAIT;
      okse_pkg::S_WAIT: state_next = need_shift ? okse_pkg::S_SHIFT : okse_pkg::S_REPLY;
      okse_pkg::S_SHIFT: if (sts.shift_done) state_next = okse_pkg::S_REPLY;
      okse_pkg::S_REPLY: if (out_fire) state_next = okse_pkg::S_IDLE;
      default: state_next = okse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      okse_pkg::S_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      okse_pkg::S_SEARCH: cmd.search = 1'b1;
      okse_pkg::S_FETCH: cmd.fetch = 1'b1;
      okse_pkg::S_WAIT: cmd.decide = 1'b1;
      okse_pkg::S_SHIFT: cmd.shift_step = 1'b1;
      okse_pkg::S_REPLY: out_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

/* design/okse_datapath.sv */
`default_nettype none
`include "ordered_key_set_engine_assert.svh"
module okse_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire okse_pkg::cmd_t cmd,
  input  wire okse_pkg::req_t req,
  output okse_pkg::sts_t sts,
  output logic need_shift,
  output okse_pkg::rsp_t rsp
);

  logic signed [31:0] mem [okse_pkg::Capacity];
  logic [2:0] op;
  logic signed [31:0] key;
  logic [okse_pkg::CountW-1:0] count;
  // binary search bounds
  logic [okse_pkg::CountW-1:0] lo, hi, mid;
  logic signed [31:0] rd;
  logic signed [31:0] rd2;
  logic rd_ok;
  logic [okse_pkg::CountW-1:0] pos;
  logic held;
  logic do_ins, do_del, do_next;
  logic [okse_pkg::CountW-1:0] sh_idx, sh_end;
  logic sh_first;
  logic [1:0] status, status_next;
  logic signed [31:0] value, value_next;
  logic [okse_pkg::AddrW-1:0] raddr, waddr;
  logic wen;
  logic signed [31:0] wdata;

  assign mid = lo + ((hi - lo) >> 1);

  always_comb begin
    sts.search_done = (lo == hi) && !rd_ok;
    sts.shift_done = (op == okse_pkg::OP_SUCC) ? !sh_first : (sh_idx >= sh_end);
  end

  // read port: search probe or neighbor fetch or shift read
  always_comb begin
    raddr = mid[okse_pkg::AddrW-1:0];
    if (cmd.fetch) raddr = pos[okse_pkg::AddrW-1:0];
    else if (cmd.shift_step) raddr = sh_idx[okse_pkg::AddrW-1:0];
  end

  // insert writes the key, then each old entry one slot up from the read of the
  // cycle before; delete writes each read entry one slot down
  always_comb begin
    wen = 1'b0;
    waddr = sh_idx[okse_pkg::AddrW-1:0];
    wdata = sh_first ? key : rd;
    if (cmd.shift_step) begin
      if (op == okse_pkg::OP_INSERT) wen = 1'b1;
      else if (op == okse_pkg::OP_DELETE) begin
        wen = !sh_first;
        waddr = okse_pkg::AddrW'(sh_idx - 2'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[raddr];
    if (pos != '0) rd2 <= mem[okse_pkg::AddrW'(pos - 1'b1)];
    if (wen) mem[waddr] <= wdata;
  end

  // rd holds the entry at pos and rd2 the one below it while deciding
  always_comb begin
    held = (pos < count) && (rd == key);
    status_next = okse_pkg::ST_NONE;
    value_next = '0;
    do_ins = 1'b0;
    do_del = 1'b0;
    do_next = 1'b0;
    unique case (op)
      okse_pkg::OP_INSERT: begin
        status_next = okse_pkg::ST_DONE;
        if (!held) begin
          if (count >= okse_pkg::CountW'(okse_pkg::Capacity)) status_next = okse_pkg::ST_FULL;
          else do_ins = 1'b1;
        end
      end
      okse_pkg::OP_DELETE: begin
        status_next = okse_pkg::ST_DONE;
        do_del = held;
      end
      okse_pkg::OP_EXISTS: status_next = held ? okse_pkg::ST_FOUND : okse_pkg::ST_NONE;
      okse_pkg::OP_PRED: if (pos != '0) begin
        status_next = okse_pkg::ST_FOUND;
        value_next = rd2;
      end
      okse_pkg::OP_SUCC: begin
        if (held) begin
          // next entry still to be read
          if (pos + 1'b1 < count) begin
            status_next = okse_pkg::ST_FOUND;
            do_next = 1'b1;
          end
        end else if (pos < count) begin
          status_next = okse_pkg::ST_FOUND;
          value_next = rd;
        end
      end
      default: status_next = okse_pkg::ST_NONE;
    endcase
  end

  assign need_shift = do_ins || do_del || do_next;

  // search runs as: issue read, then compare (rd_ok marks data valid)
  always_ff @(posedge clk) begin
    if (rst) begin
      op <= '0;
      key <= '0;
      count <= '0;
      lo <= '0;
      hi <= '0;
      rd_ok <= 1'b0;
      pos <= '0;
      sh_idx <= '0;
      sh_end <= '0;
      sh_first <= 1'b0;
      status <= '0;
      value <= '0;
    end else begin
      if (cmd.load) begin
        op <= req.operation;
        key <= req.key;
        lo <= '0;
        hi <= count;
        rd_ok <= 1'b0;
      end
      if (cmd.search && lo != hi) begin
        if (!rd_ok) rd_ok <= 1'b1;
        else begin
          rd_ok <= 1'b0;
          if (rd < key) lo <= mid + 1'b1;
          else hi <= mid;
        end
      end
      if (cmd.search && lo == hi) pos <= lo;
      if (cmd.decide) begin
        status <= status_next;
        value <= value_next;
        sh_first <= 1'b1;
        sh_end <= count;
        if (do_ins) begin
          sh_idx <= pos;
          count <= count + 1'b1;
        end else begin
          sh_idx <= pos + 1'b1;
          if (do_del) count <= count - 1'b1;
        end
      end
      if (cmd.shift_step) begin
        sh_first <= 1'b0;
        sh_idx <= sh_idx + 1'b1;
        if (op == okse_pkg::OP_SUCC) value <= rd;
      end
    end
  end

  assign rsp = {status, value, 9'(count)};

  `OKS_ASSERT(a_count_cap, clk, rst, count <= okse_pkg::CountW'(okse_pkg::Capacity),
              "count above capacity")
  `OKS_ASSERT(a_bounds, clk, rst, lo <= hi, "search bounds crossed")
  `OKS_ASSERT_NEXT(a_load_clear, clk, rst, cmd.load, !rd_ok, "probe flag not cleared")

endmodule
`default_nettype wire

/* design/ordered_key_set_engine.sv */
// channel   role   payload
// req       sink   operation, key
// rsp       source status, value, stored_count
// One request at a time: binary search works in steps of a read and a compare, at
// most 9 steps for a full store, then the settle, fetch and decide states follow.
// Insert then writes count - pos + 1 entries, one per cycle; delete of a held key
// moves each entry above pos one slot down; successor of a held key reads the next entry.
// Reset clears the count; memory contents need no clearing. A stalled result holds.
`default_nettype none
module ordered_key_set_engine (
  input wire logic clk,
  input wire logic rst,
  okse_req_if.sink req,
  okse_rsp_if.source rsp
);

  okse_pkg::cmd_t cmd;
  okse_pkg::sts_t sts;
  logic busy, need_shift, out_valid;

  assign req.ready = !busy;
  assign rsp.valid = out_valid;

  okse_ctrl u_ctrl (
    .clk, .rst,
    .in_fire(req.valid && req.ready),
    .out_fire(rsp.valid && rsp.ready),
    .need_shift, .sts, .cmd, .busy, .out_valid
  );

  okse_datapath u_dp (
    .clk, .rst, .cmd, .req(req.payload), .sts, .need_shift, .rsp(rsp.payload)
  );

endmodule
`default_nettype wire
